// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation and status codes shared by the queue control logic.
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   // Operation codes carried by each request. Code 7 is unused and is treated
   // as a no-operation.
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK_FRONT = 3'd4,
      OP_PEEK_BACK  = 3'd5,
      OP_CLEAR      = 3'd6
   } op_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CountWidth = 9;

endpackage

`default_nettype wire

// ===== src/dq_ram.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue entry store
// Single-port synchronous memory with a registered read, one access a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dq_ram
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   addr,
   input  wire logic [ValueWidth-1:0]      wr_data,
   output logic      [ValueWidth-1:0]      rd_data
);

   logic [ValueWidth-1:0] mem [DEPTH];
   logic [ValueWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== src/double_ended_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of 32-bit signed values held in a ring-organised memory.
// ----------------------------------------------------------------------------
// Each request transfer carries an operation and a push value and yields
// exactly one response transfer holding a status, the popped or peeked value,
// an empty flag and the entry count after the operation. For pushes, clear
// and the unused code, the memory write and the pointer update happen at the
// edge at which the request is accepted, and the response register is loaded
// at that same edge. Pops and peeks on a non-empty queue read the single
// memory port: the read is issued at acceptance, no request is accepted while
// it is outstanding, and the response register is loaded when its data
// arrives. A new request is accepted while the previous response is being
// transferred, so a stream of pushes runs at one transfer per cycle while the
// response side does not stall. The memory is not initialised; only occupied
// entries are ever read, so no clearing pass is required after reset. A push
// into a full queue reports full and leaves the contents untouched; a pop or
// peek on an empty queue reports empty with a zero value.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // Request channel
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic        [2:0]            req_op,
   input  wire logic signed [ValueWidth-1:0] req_push_value,
   // Response channel
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic             [1:0]            rsp_status,
   output logic signed      [ValueWidth-1:0] rsp_read_value,
   output logic                              rsp_is_empty,
   output logic             [CountWidth-1:0] rsp_entry_count
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LastIndex = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FullCount = CW'(DEPTH);

   // Pointer and occupancy state.
   logic [AW-1:0] front_ff, front_in;
   logic [AW-1:0] back_ff, back_in;
   logic [CW-1:0] occ_ff, occ_in;

   // A memory read is outstanding; its data arrives in this cycle.
   logic rd_pending_ff, rd_pending_in;

   // Response register.
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [ValueWidth-1:0] value_ff, value_in;
   logic                  empty_ff, empty_in;
   logic [CW-1:0]         count_ff, count_in;

   // Memory access.
   logic                  mem_wr_en;
   logic                  mem_rd_en;
   logic [AW-1:0]         mem_addr;
   logic [ValueWidth-1:0] mem_rd_data;

   logic req_take;
   logic rsp_free;
   logic is_full;
   logic is_zero;
   logic [AW-1:0] front_inc, front_dec, back_inc, back_dec;

   // The response register is free when empty or being transferred now.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = rd_pending_ff || !rsp_free;
   assign req_take  = req_valid && !req_stall;

   assign is_full = (occ_ff == FullCount);
   assign is_zero = (occ_ff == '0);

   // Ring arithmetic; the depth need not be a power of two.
   assign front_inc = (front_ff == LastIndex) ? '0 : front_ff + AW'(1);
   assign front_dec = (front_ff == '0) ? LastIndex : front_ff - AW'(1);
   assign back_inc  = (back_ff == LastIndex) ? '0 : back_ff + AW'(1);
   assign back_dec  = (back_ff == '0) ? LastIndex : back_ff - AW'(1);

   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      occ_in        = occ_ff;
      rd_pending_in = 1'b0;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_addr      = front_ff;
      status_in     = status_ff;
      value_in      = value_ff;
      empty_in      = empty_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (rd_pending_ff) begin
         // Read data has arrived: complete the held response.
         value_in     = mem_rd_data;
         rsp_valid_in = 1'b1;
      end else if (req_take) begin
         status_in = ST_OK;
         value_in  = '0;
         case (req_op) inside
            OP_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  mem_wr_en = 1'b1;
                  mem_addr  = front_dec;
                  front_in  = front_dec;
                  occ_in    = occ_ff + CW'(1);
               end
            end
            OP_PUSH_BACK: begin
               if (is_full) begin
                  status_in = ST_FULL;
               end else begin
                  mem_wr_en = 1'b1;
                  mem_addr  = back_ff;
                  back_in   = back_inc;
                  occ_in    = occ_ff + CW'(1);
               end
            end
            OP_POP_FRONT, OP_PEEK_FRONT: begin
               if (is_zero) begin
                  status_in = ST_EMPTY;
               end else begin
                  mem_rd_en     = 1'b1;
                  mem_addr      = front_ff;
                  rd_pending_in = 1'b1;
                  if (req_op == OP_POP_FRONT) begin
                     front_in = front_inc;
                     occ_in   = occ_ff - CW'(1);
                  end
               end
            end
            OP_POP_BACK, OP_PEEK_BACK: begin
               if (is_zero) begin
                  status_in = ST_EMPTY;
               end else begin
                  mem_rd_en     = 1'b1;
                  mem_addr      = back_dec;
                  rd_pending_in = 1'b1;
                  if (req_op == OP_POP_BACK) begin
                     back_in = back_dec;
                     occ_in  = occ_ff - CW'(1);
                  end
               end
            end
            OP_CLEAR: begin
               front_in = '0;
               back_in  = '0;
               occ_in   = '0;
            end
            default: begin
               // Unused code: report ok and change nothing.
            end
         endcase
         empty_in     = (occ_in == '0);
         count_in     = occ_in;
         // A read response is held back until its data arrives.
         rsp_valid_in = !rd_pending_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         back_ff       <= '0;
         occ_ff        <= '0;
         rd_pending_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         front_ff      <= front_in;
         back_ff       <= back_in;
         occ_ff        <= occ_in;
         rd_pending_ff <= rd_pending_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      value_ff  <= value_in;
      empty_ff  <= empty_in;
      count_ff  <= count_in;
   end

   dq_ram #(
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (unsigned'(req_push_value)),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_read_value  = signed'(value_ff);
   assign rsp_is_empty    = empty_ff;
   assign rsp_entry_count = CountWidth'(count_ff);

   // An outstanding read always completes into a valid response next cycle.
   a_read_completes: assert property (@(posedge clock) disable iff (reset)
      rd_pending_ff |=> rsp_valid_ff)
      else $error("read did not complete into a response");

   // Occupancy never exceeds the depth.
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FullCount)
      else $error("occupancy exceeds depth");

   // Empty or full, the two ends of the ring coincide.
   a_ends_meet: assert property (@(posedge clock) disable iff (reset)
      (is_zero || is_full) |-> (front_ff == back_ff))
      else $error("pointers disagree with occupancy");

   // No request is taken while a read from the front is outstanding.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_op == OP_POP_FRONT || req_op == OP_PEEK_FRONT)
       && !is_zero) |=> !req_take)
      else $error("request accepted during a memory read");

endmodule

`default_nettype wire

// ===== tb/double_ended_queue_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Watches both channels of the queue unit, keeps its own copy of the ring and
// compares every response transfer, field by field, with the awaited outcome.
// ----------------------------------------------------------------------------

module double_ended_queue_checker
   import dq_pkg::*;
#(
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic                         req_stall,
   input  wire logic        [2:0]            req_op,
   input  wire logic signed [ValueWidth-1:0] req_push_value,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   input  wire logic        [1:0]            rsp_status,
   input  wire logic signed [ValueWidth-1:0] rsp_read_value,
   input  wire logic                         rsp_is_empty,
   input  wire logic        [CountWidth-1:0] rsp_entry_count,
   output int                                fail_count,
   output int                                awaited_count
);

   typedef struct {
      status_type                    status;
      logic signed [ValueWidth-1:0]  read_value;
      logic                          empty_flag;
      logic        [CountWidth-1:0]  entry_count;
   } deque_outcome_type;

   deque_outcome_type awaited_outcomes[$];

   logic signed [ValueWidth-1:0] slots [DEPTH];
   int unsigned head;
   int unsigned tail;
   int unsigned held;
   int          mismatches = 0;

   initial begin
      fail_count    = 0;
      awaited_count = 0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t ns: %s", $time, msg);
      mismatches++;
   endtask

   // Applies one operation to the local ring and returns the outcome it gives.
   function automatic deque_outcome_type apply_deque_op(input logic [2:0] op,
                                                        input logic signed [ValueWidth-1:0] value);
      deque_outcome_type outcome;
      int unsigned       last;
      outcome.status     = ST_OK;
      outcome.read_value = '0;
      case (op) inside
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (held >= DEPTH) begin
               outcome.status = ST_FULL;
            end else if (op == OP_PUSH_FRONT) begin
               head        = (head + DEPTH - 1) % DEPTH;
               slots[head] = value;
               held++;
            end else begin
               slots[tail] = value;
               tail        = (tail + 1) % DEPTH;
               held++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK, OP_PEEK_FRONT, OP_PEEK_BACK: begin
            if (held == 0) begin
               outcome.status = ST_EMPTY;
            end else if (op == OP_POP_FRONT || op == OP_PEEK_FRONT) begin
               outcome.read_value = slots[head];
               if (op == OP_POP_FRONT) begin
                  head = (head + 1) % DEPTH;
                  held--;
               end
            end else begin
               last               = (tail + DEPTH - 1) % DEPTH;
               outcome.read_value = slots[last];
               if (op == OP_POP_BACK) begin
                  tail = last;
                  held--;
               end
            end
         end
         OP_CLEAR: begin
            head = 0;
            tail = 0;
            held = 0;
         end
         default: begin
         end
      endcase
      outcome.empty_flag  = (held == 0);
      outcome.entry_count = CountWidth'(held);
      return outcome;
   endfunction

   // The response is checked before the request of the same edge is predicted,
   // since a response can never belong to a request accepted at that edge.
   always @(posedge clock) begin
      deque_outcome_type want;
      deque_outcome_type predicted;
      if (reset) begin
         head = 0;
         tail = 0;
         held = 0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("response transfer with no outcome awaited");
            end else begin
               want = awaited_outcomes[0];
               awaited_outcomes.delete(0);
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status: expected %0d, got %0d",
                                            want.status, rsp_status));
               if (rsp_read_value !== want.read_value)
                  report_mismatch($sformatf("read_value: expected %0d, got %0d",
                                            want.read_value, rsp_read_value));
               if (rsp_is_empty !== want.empty_flag)
                  report_mismatch($sformatf("empty flag: expected %0d, got %0d",
                                            want.empty_flag, rsp_is_empty));
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                            want.entry_count, rsp_entry_count));
            end
         end
         if (req_valid && !req_stall) begin
            predicted = apply_deque_op(req_op, req_push_value);
            awaited_outcomes.insert(awaited_outcomes.size(), predicted);
         end
      end
      awaited_count <= awaited_outcomes.size();
      fail_count    <= mismatches;
   end

endmodule

// ===== tb/tb_double_ended_queue_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives directed and phased random operations into the queue unit with
// random gaps and stalls, and takes the verdict from the attached checker.
// ----------------------------------------------------------------------------

module tb_double_ended_queue_unit;
   import dq_pkg::*;

   localparam int unsigned QueueDepth  = 256;
   localparam int          RandomItems = 1900;
   localparam int          CycleLimit  = 600000;
   localparam int          DrainCycles = 10;

   // Code 7 has no name in the package; the block must treat it as a no-op.
   localparam logic [2:0] OpUnused = 3'd7;

   localparam logic signed [ValueWidth-1:0] ValueMin = 32'sh8000_0000;
   localparam logic signed [ValueWidth-1:0] ValueMax = 32'sh7fff_ffff;

   // Kinds of random phase: filling pushes the queue up against full,
   // draining runs it down to empty, mixed wanders around the middle.
   localparam int PhaseFill  = 0;
   localparam int PhaseDrain = 1;
   localparam int PhaseMixed = 2;

   logic                          clock          = 1'b0;
   logic                          reset          = 1'b1;
   logic                          req_valid      = 1'b0;
   logic                          req_stall;
   logic        [2:0]             req_op         = '0;
   logic signed [ValueWidth-1:0]  req_push_value = '0;
   logic                          rsp_valid;
   logic                          rsp_stall      = 1'b0;
   logic        [1:0]             rsp_status;
   logic signed [ValueWidth-1:0]  rsp_read_value;
   logic                          rsp_is_empty;
   logic        [CountWidth-1:0]  rsp_entry_count;

   int failures;
   int outstanding;
   int cycles = 0;

   // When set, both sides run flat out with neither gaps nor stalls.
   bit quiet = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   double_ended_queue_unit #(
      .DEPTH(QueueDepth)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_entry_count(rsp_entry_count)
   );

   double_ended_queue_checker #(
      .DEPTH(QueueDepth)
   ) deque_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_entry_count(rsp_entry_count),
      .fail_count     (failures),
      .awaited_count  (outstanding)
   );

   // A hung handshake must not leave the run waiting for ever. The limit is
   // several times the slowest correct run: every item with the longest gap,
   // the memory read path and the longest stall.
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Offers one request transfer. The task is entered at a rising edge and
   // returns at the edge at which the transfer took place. When no gap is
   // drawn, valid simply stays high, so it is never lowered and raised again
   // within one time step.
   task automatic offer_request(input logic [2:0] op,
                                input logic signed [ValueWidth-1:0] value);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_push_value <= value;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Response side: before each transfer a stall of random length is drawn
   // and held, then stall is released until the transfer has happened. Stall
   // is only ever raised at an edge where it is already low, and lowered at a
   // different edge, so each step sees at most one assignment to it.
   initial begin : response_side
      int hold;
      wait (!reset);
      @(posedge clock);
      forever begin
         hold = quiet ? 0 : $urandom_range(0, 12);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   initial begin : request_side
      int                           sent;
      int                           phase_no;
      int                           kind;
      int                           phase_len;
      int                           pick;
      int                           push_pct;
      int                           pop_pct;
      int                           peek_limit;
      logic [2:0]                   op;
      logic signed [ValueWidth-1:0] value;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part. It starts on the empty queue with every pop and peek
      // and the unused code, then loads the extreme values from both ends so
      // that the front pointer wraps below zero, and checks clear both on a
      // loaded queue and on an empty one.
      offer_request(OP_POP_FRONT,  32'sd1);
      offer_request(OP_POP_BACK,   32'sd2);
      offer_request(OP_PEEK_FRONT, 32'sd3);
      offer_request(OP_PEEK_BACK,  32'sd4);
      offer_request(OpUnused,      ValueMax);
      offer_request(OP_PUSH_BACK,  ValueMax);
      offer_request(OP_PUSH_FRONT, ValueMin);
      offer_request(OP_PUSH_BACK,  -32'sd1);
      offer_request(OP_PUSH_FRONT, 32'sd0);
      offer_request(OP_PEEK_FRONT, 32'sd0);
      offer_request(OP_PEEK_BACK,  32'sd0);
      offer_request(OP_POP_FRONT,  ValueMin);
      offer_request(OP_POP_BACK,   ValueMax);
      offer_request(OP_PEEK_FRONT, -32'sd1);
      offer_request(OP_PEEK_BACK,  -32'sd1);
      offer_request(OpUnused,      32'sh1234_5678);
      offer_request(OP_CLEAR,      -32'sd1);
      offer_request(OP_PEEK_BACK,  32'sd0);
      offer_request(OP_PUSH_FRONT, 32'sh5555_5555);
      offer_request(OP_POP_BACK,   32'sd0);
      offer_request(OP_PUSH_BACK,  32'shaaaa_aaaa);
      offer_request(OP_POP_FRONT,  32'sd0);
      offer_request(OP_CLEAR,      32'sd0);

      // Random part, in phases. The first phase is always a filling phase, so
      // that pushes against a full queue are likely to be seen. Each phase
      // also decides whether the two sides idle at all.
      sent     = 0;
      phase_no = 0;
      while (sent < RandomItems) begin
         kind      = (phase_no == 0) ? PhaseFill : $urandom_range(PhaseFill, PhaseMixed);
         phase_len = (kind == PhaseFill) ? $urandom_range(200, 400) : $urandom_range(30, 150);
         quiet     = ($urandom_range(0, 3) == 0);
         case (kind)
            PhaseFill: begin
               push_pct   = 94;
               pop_pct    = 3;
               peek_limit = 100;
            end
            PhaseDrain: begin
               push_pct   = 8;
               pop_pct    = 88;
               peek_limit = 100;
            end
            default: begin
               push_pct   = 40;
               pop_pct    = 30;
               peek_limit = 94;
            end
         endcase
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
               op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if (pick < push_pct + pop_pct)
               op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            else if (pick < peek_limit)
               op = $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
            else if (pick < 98)
               op = OP_CLEAR;
            else
               op = OpUnused;
            // Mostly random words, with the corner values now and then.
            if ($urandom_range(0, 7) == 0) begin
               case ($urandom_range(0, 3))
                  0:       value = ValueMin;
                  1:       value = ValueMax;
                  2:       value = -32'sd1;
                  default: value = 32'sd0;
               endcase
            end else begin
               value = $urandom;
            end
            offer_request(op, value);
            sent++;
         end
         phase_no++;
      end
      req_valid <= 1'b0;

      // The count from the checker is registered, so it is trusted only after the
      // next edge. Then the queue of awaited outcomes must run dry, after which a
      // further DrainCycles edges catch any stray response.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (failures == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
